// ----- sv/kst_pkg.sv -----
// shared types and codes for the keyed slot table
`timescale 1ns / 1ps
`default_nettype none
package kst_pkg;

  localparam int ID_W     = 32;
  localparam int ATTR_W   = 32;
  localparam int HANDLE_W = 64;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 2;
  localparam int IDX_W    = 6;
  localparam int CFG_W    = 7;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MODIFY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_HANDLE = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [ATTR_W-1:0]   attr;
    logic [HANDLE_W-1:0] handle;
  } slot_entry_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic              load;
    logic              clear;
    logic              scan;
    logic              commit;
    logic              report;
    logic [STAT_W-1:0] status;
  } kst_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic bad_handle;
    logic hit;
    logic miss;
    logic clear_last;
  } kst_stat_t;

endpackage
`default_nettype wire

// ----- sv/kst_ctrl.sv -----
// controller state machine for the keyed slot table
`timescale 1ns / 1ps
`default_nettype none
module kst_ctrl
  import kst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire kst_stat_t dp_stat,
  output kst_cmd_t       dp_cmd
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    unique case (state_r)
      S_CLEAR: begin
        dp_cmd.clear = 1'b1;
        if (dp_stat.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (dp_stat.bad_handle) begin
            // add with a zero handle is answered at once
            dp_cmd.report = 1'b1;
            dp_cmd.status = ST_BAD_HANDLE;
          end else begin
            dp_cmd.load = 1'b1;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        dp_cmd.scan = 1'b1;
        if (dp_stat.hit) begin
          dp_cmd.commit = 1'b1;
          dp_cmd.report = 1'b1;
          dp_cmd.status = ST_OK;
          state_nxt     = S_IDLE;
        end else if (dp_stat.miss) begin
          dp_cmd.report = 1'b1;
          dp_cmd.status = ST_NOT_FOUND;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule
`default_nettype wire

// ----- sv/kst_dpath.sv -----
// slot memory, scan counter, compare and result registers
`timescale 1ns / 1ps
`default_nettype none
module kst_dpath
  import kst_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire kst_cmd_t            dp_cmd,
  output kst_stat_t                dp_stat,
  input  wire logic [CFG_W-1:0]    entries_in_use,
  input  wire logic [CMD_W-1:0]    in_cmd,
  input  wire logic [ID_W-1:0]     in_entry_id,
  input  wire logic [ATTR_W-1:0]   in_entry_attr,
  input  wire logic [HANDLE_W-1:0] in_entry_handle,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic [IDX_W-1:0]         out_slot_index,
  output logic [ATTR_W-1:0]        out_found_attr,
  output logic [HANDLE_W-1:0]      out_found_handle
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;

  slot_entry_t slot_mem [SLOT_COUNT];

  logic [CMD_W-1:0]    cmd_r;
  logic [ID_W-1:0]     id_r;
  logic [ID_W-1:0]     key_r;
  logic [ATTR_W-1:0]   attr_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [LW-1:0]       limit_r;
  logic [LW-1:0]       cnt_r;
  logic [LW-1:0]       cnt_nxt;
  logic                rd_vld_r;
  logic                rd_vld_nxt;
  logic [AW-1:0]       addr_q_r;
  slot_entry_t         rd_entry_r;
  logic                in_range;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  slot_entry_t         mem_wdata;
  logic                out_valid_r;
  logic [STAT_W-1:0]   out_status_r;
  logic [IDX_W-1:0]    out_slot_index_r;
  logic [ATTR_W-1:0]   out_found_attr_r;
  logic [HANDLE_W-1:0] out_found_handle_r;

  // request capture; searches clamp to the table size
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r    <= in_cmd;
      id_r     <= in_entry_id;
      key_r    <= (in_cmd == CMD_ADD) ? '0 : in_entry_id;
      attr_r   <= in_entry_attr;
      handle_r <= in_entry_handle;
      limit_r  <= (LW'(entries_in_use) > LW'(SLOT_COUNT)) ? LW'(SLOT_COUNT)
                                                           : LW'(entries_in_use);
    end
  end

  assign in_range = (cnt_r < limit_r);

  always_comb begin
    cnt_nxt = cnt_r;
    if (dp_cmd.load) begin
      cnt_nxt = '0;
    end else if (dp_cmd.clear || (dp_cmd.scan && in_range)) begin
      cnt_nxt = cnt_r + LW'(1);
    end
  end

  assign rd_vld_nxt = dp_cmd.scan && in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // write side: clearing pass or the update of the matched slot
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q_r;
    mem_wdata = '0;
    if (dp_cmd.clear) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r[AW-1:0];
    end else if (dp_cmd.commit) begin
      case (cmd_r)
        CMD_ADD: begin
          mem_we           = 1'b1;
          mem_wdata.id     = id_r;
          mem_wdata.attr   = attr_r;
          mem_wdata.handle = handle_r;
        end
        CMD_MODIFY: begin
          mem_we           = 1'b1;
          mem_wdata.id     = rd_entry_r.id;
          mem_wdata.attr   = attr_r;
          mem_wdata.handle = handle_r;
        end
        CMD_DELETE: begin
          mem_we = 1'b1;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_entry_r <= slot_mem[cnt_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    addr_q_r <= cnt_r[AW-1:0];
  end

  assign dp_stat.bad_handle = (in_cmd == CMD_ADD) && (in_entry_handle == '0);
  assign dp_stat.hit        = rd_vld_r && (rd_entry_r.id == key_r);
  assign dp_stat.miss       = !rd_vld_r && !in_range;
  assign dp_stat.clear_last = (cnt_r == LW'(SLOT_COUNT - 1));

  // result registers, fields are zero unless the request found a slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dp_cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.report) begin
      out_status_r <= dp_cmd.status;
      if (dp_cmd.status == ST_OK) begin
        out_slot_index_r   <= IDX_W'(addr_q_r);
        out_found_attr_r   <= rd_entry_r.attr;
        out_found_handle_r <= rd_entry_r.handle;
      end else begin
        out_slot_index_r   <= '0;
        out_found_attr_r   <= '0;
        out_found_handle_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot_index   = out_slot_index_r;
  assign out_found_attr   = out_found_attr_r;
  assign out_found_handle = out_found_handle_r;

endmodule
`default_nettype wire

// ----- sv/keyed_slot_table.sv -----
// top level of the keyed slot table
//
// A table of SLOT_COUNT slots (id, attribute, handle); id zero marks a free slot.
// Request channel: start/busy. A request (in_cmd, in_entry_id, in_entry_attr,
// in_entry_handle) is taken at a clock edge with start high and busy low.
// Commands: add, modify, delete, lookup. Each searches slots below
// min(entries_in_use, SLOT_COUNT) in order, one slot per cycle, first match wins.
// Result channel: out_valid is high for one cycle with out_status,
// out_slot_index, out_found_attr and out_found_handle; the receiver cannot stall
// it, and the result registers hold until the next result.
// Reply order: out_valid is registered from the controller's report; a hit on slot k
// reports once slot k has been read into rd_entry_r and matched, a miss once the
// counter reaches the clamped search range with no read pending; an add with a zero
// handle raises out_valid at the request edge itself. busy falls as out_valid rises;
// the time a request takes is set by the single-read-port slot memory scan.
// Configuration: cfg_valid/cfg_ready write entries_in_use, always ready.
// Reset: entries_in_use returns to 0 and a clearing pass zeroes every slot in turn
// with busy high; configuration writes are taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module keyed_slot_table
  import kst_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    in_cmd,
  input  wire logic [ID_W-1:0]     in_entry_id,
  input  wire logic [ATTR_W-1:0]   in_entry_attr,
  input  wire logic [HANDLE_W-1:0] in_entry_handle,
  output logic                     out_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic [IDX_W-1:0]         out_slot_index,
  output logic [ATTR_W-1:0]        out_found_attr,
  output logic [HANDLE_W-1:0]      out_found_handle,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_W-1:0]    cfg_entries_in_use
);

  logic [CFG_W-1:0] entries_in_use_r;
  kst_cmd_t         dp_cmd;
  kst_stat_t        dp_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entries_in_use_r <= cfg_entries_in_use;
    end
  end

  kst_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .dp_stat (dp_stat),
    .dp_cmd  (dp_cmd)
  );

  kst_dpath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .dp_cmd           (dp_cmd),
    .dp_stat          (dp_stat),
    .entries_in_use   (entries_in_use_r),
    .in_cmd           (in_cmd),
    .in_entry_id      (in_entry_id),
    .in_entry_attr    (in_entry_attr),
    .in_entry_handle  (in_entry_handle),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_slot_index   (out_slot_index),
    .out_found_attr   (out_found_attr),
    .out_found_handle (out_found_handle)
  );

endmodule
`default_nettype wire

// ----- sim/keyed_slot_table_checker.sv -----
// reply checker for the keyed slot table: tracks the table, predicts each reply and compares
`timescale 1ns / 1ps
module keyed_slot_table_checker
  import kst_pkg::*;
#(
  parameter int SLOT_COUNT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [ID_W-1:0]     in_entry_id,
  input  logic [ATTR_W-1:0]   in_entry_attr,
  input  logic [HANDLE_W-1:0] in_entry_handle,
  input  logic                out_valid,
  input  logic [STAT_W-1:0]   out_status,
  input  logic [IDX_W-1:0]    out_slot_index,
  input  logic [ATTR_W-1:0]   out_found_attr,
  input  logic [HANDLE_W-1:0] out_found_handle,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CFG_W-1:0]    cfg_entries_in_use,
  output int                  replies_due,
  output int                  error_count,
  output int                  replies_checked
);

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [IDX_W-1:0]    slot;
    logic [ATTR_W-1:0]   attr;
    logic [HANDLE_W-1:0] handle;
  } table_reply_t;

  logic [ID_W-1:0]     shadow_id     [SLOT_COUNT];
  logic [ATTR_W-1:0]   shadow_attr   [SLOT_COUNT];
  logic [HANDLE_W-1:0] shadow_handle [SLOT_COUNT];
  logic [CFG_W-1:0]    search_range;

  table_reply_t reply_queue [$];
  table_reply_t got_reply;
  table_reply_t want_reply;
  int           fail_total = 0;
  int           checked_total = 0;

  // applies one request to the shadow table and returns the reply it should produce
  function automatic table_reply_t apply_request(input logic [CMD_W-1:0] cmd,
                                                 input logic [ID_W-1:0] id,
                                                 input logic [ATTR_W-1:0] attr,
                                                 input logic [HANDLE_W-1:0] handle);
    table_reply_t     r;
    logic [ID_W-1:0]  key;
    int               span;
    int               hit;
    r = '0;
    if (cmd == CMD_ADD && handle == '0) begin
      r.status = ST_BAD_HANDLE;
      return r;
    end
    // add hunts for a free slot, everything else for the given id
    key  = (cmd == CMD_ADD) ? '0 : id;
    span = (search_range > SLOT_COUNT) ? SLOT_COUNT : int'(search_range);
    hit  = -1;
    for (int i = 0; i < span; i++) begin
      if (hit < 0 && shadow_id[i] == key) hit = i;
    end
    if (hit < 0) begin
      r.status = ST_NOT_FOUND;
      return r;
    end
    r.status = ST_OK;
    r.slot   = hit[IDX_W-1:0];
    r.attr   = shadow_attr[hit];
    r.handle = shadow_handle[hit];
    case (cmd)
      CMD_ADD: begin
        shadow_id[hit]     = id;
        shadow_attr[hit]   = attr;
        shadow_handle[hit] = handle;
      end
      CMD_MODIFY: begin
        shadow_attr[hit]   = attr;
        shadow_handle[hit] = handle;
      end
      CMD_DELETE: begin
        shadow_id[hit]     = '0;
        shadow_attr[hit]   = '0;
        shadow_handle[hit] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_failure(input string msg);
    fail_total++;
    if (fail_total <= 10) $display("[%0t] %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        shadow_id[i]     = '0;
        shadow_attr[i]   = '0;
        shadow_handle[i] = '0;
      end
      search_range = '0;
      reply_queue.delete();
    end else begin
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) search_range = cfg_entries_in_use;
      if (out_valid === 1'b1) begin
        got_reply = '{out_status, out_slot_index, out_found_attr, out_found_handle};
        checked_total++;
        if (reply_queue.size() == 0) begin
          note_failure($sformatf("reply with no request pending: status %0d slot %0d attr %h handle %h",
                                 got_reply.status, got_reply.slot, got_reply.attr,
                                 got_reply.handle));
        end else begin
          want_reply = reply_queue.pop_front();
          if (got_reply !== want_reply) begin
            note_failure($sformatf({"reply %0d: expected status %0d slot %0d attr %h handle %h,",
                                    " got status %0d slot %0d attr %h handle %h"},
                                   checked_total, want_reply.status, want_reply.slot,
                                   want_reply.attr, want_reply.handle, got_reply.status,
                                   got_reply.slot, got_reply.attr, got_reply.handle));
          end
        end
      end
      // a reply for this request cannot come at the same edge, so pop before push
      if (start === 1'b1 && busy === 1'b0) begin
        reply_queue.push_back(apply_request(in_cmd, in_entry_id, in_entry_attr,
                                            in_entry_handle));
      end
    end
    replies_due     <= reply_queue.size();
    error_count     <= fail_total;
    replies_checked <= checked_total;
  end

endmodule

// ----- sim/keyed_slot_table_tb.sv -----
// testbench top for the keyed slot table: request stimulus, range settings and the verdict
`timescale 1ns / 1ps
module keyed_slot_table_tb;
  import kst_pkg::*;

  localparam int SLOT_COUNT  = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = SLOT_COUNT + 8;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    in_cmd;
  logic [ID_W-1:0]     in_entry_id;
  logic [ATTR_W-1:0]   in_entry_attr;
  logic [HANDLE_W-1:0] in_entry_handle;
  logic                out_valid;
  logic [STAT_W-1:0]   out_status;
  logic [IDX_W-1:0]    out_slot_index;
  logic [ATTR_W-1:0]   out_found_attr;
  logic [HANDLE_W-1:0] out_found_handle;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_entries_in_use;

  int replies_due;
  int error_count;
  int replies_checked;
  int cycle_count = 0;
  int sent_by_cmd [4];
  int ranges_used = 0;
  bit burst_mode = 1'b0;

  always #2 clk = ~clk;

  keyed_slot_table #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_entry_id        (in_entry_id),
    .in_entry_attr      (in_entry_attr),
    .in_entry_handle    (in_entry_handle),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_found_attr     (out_found_attr),
    .out_found_handle   (out_found_handle),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_entries_in_use (cfg_entries_in_use)
  );

  keyed_slot_table_checker #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_entry_id        (in_entry_id),
    .in_entry_attr      (in_entry_attr),
    .in_entry_handle    (in_entry_handle),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_slot_index     (out_slot_index),
    .out_found_attr     (out_found_attr),
    .out_found_handle   (out_found_handle),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_entries_in_use (cfg_entries_in_use),
    .replies_due        (replies_due),
    .error_count        (error_count),
    .replies_checked    (replies_checked)
  );

  // holds the request until the edge that takes it; start stays high afterwards
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                              input logic [ATTR_W-1:0] attr,
                              input logic [HANDLE_W-1:0] handle);
    in_cmd          <= cmd;
    in_entry_id     <= id;
    in_entry_attr   <= attr;
    in_entry_handle <= handle;
    start           <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    sent_by_cmd[cmd]++;
  endtask

  task automatic pause_sender();
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (!burst_mode) begin
      if (r >= 97)      gap = $urandom_range(30, 90);
      else if (r >= 85) gap = $urandom_range(4, 12);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_replies_drained();
    start <= 1'b0;
    do @(posedge clk); while (replies_due != 0);
  endtask

  task automatic write_search_range(input logic [CFG_W-1:0] value);
    cfg_entries_in_use <= value;
    cfg_valid          <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    ranges_used++;
  endtask

  task automatic directed_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                  input logic [ATTR_W-1:0] attr,
                                  input logic [HANDLE_W-1:0] handle);
    send_request(cmd, id, attr, handle);
    pause_sender();
  endtask

  // mostly a small pool of ids so that requests hit, with free-slot and random keys mixed in
  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r >= 75) return $urandom;
    case ($urandom_range(0, 7))
      0: return 32'd1;
      1: return 32'd2;
      2: return 32'd3;
      3: return 32'hFFFF_FFFF;
      4: return 32'h8000_0000;
      5: return 32'h1234_5678;
      6: return 32'd7;
      default: return 32'd42;
    endcase
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input int add_weight);
    int r;
    r = $urandom_range(0, 99);
    if (r < add_weight) return CMD_ADD;
    case ($urandom_range(0, 2))
      0: return CMD_MODIFY;
      1: return CMD_DELETE;
      default: return CMD_LOOKUP;
    endcase
  endfunction

  task automatic random_phase(input logic [CFG_W-1:0] range, input int count,
                              input int add_weight);
    logic [HANDLE_W-1:0] handle;
    wait_replies_drained();
    write_search_range(range);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      handle = ($urandom_range(0, 9) == 0) ? '0 : {$urandom, $urandom};
      send_request(pick_cmd(add_weight), pick_id(), $urandom, handle);
      if ($urandom_range(0, 99) < 2) wait_replies_drained();
      pause_sender();
    end
    burst_mode = 1'b0;
  endtask

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("keyed_slot_table: mismatch");
    $finish;
  end

  initial begin : stimulus
    rst_n              <= 1'b0;
    start              <= 1'b0;
    in_cmd             <= CMD_LOOKUP;
    in_entry_id        <= '0;
    in_entry_attr      <= '0;
    in_entry_handle    <= '0;
    cfg_valid          <= 1'b0;
    cfg_entries_in_use <= '0;
    foreach (sent_by_cmd[i]) sent_by_cmd[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty search range: nothing is ever found, zero handle still rejected
    write_search_range(7'd0);
    directed_request(CMD_LOOKUP, 32'd0, 32'd0, 64'd0);
    directed_request(CMD_ADD, 32'd1, 32'd1, 64'd1);
    directed_request(CMD_ADD, 32'd1, 32'd1, 64'd0);

    wait_replies_drained();
    write_search_range(7'd4);
    directed_request(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
    directed_request(CMD_ADD, 32'd5, 32'd1, 64'd1);
    // duplicate id lands in the next free slot
    directed_request(CMD_ADD, 32'd5, 32'd2, 64'd2);
    directed_request(CMD_LOOKUP, 32'd5, 32'd0, 64'd0);
    directed_request(CMD_MODIFY, 32'd5, 32'd0, 64'd0);
    directed_request(CMD_DELETE, 32'd5, 32'd0, 64'd0);
    directed_request(CMD_LOOKUP, 32'd5, 32'd0, 64'd0);
    directed_request(CMD_LOOKUP, 32'd0, 32'd0, 64'd0);
    // modify and delete with id zero act on the first free slot
    directed_request(CMD_MODIFY, 32'd0, 32'hA5A5_A5A5, 64'h8000_0000_0000_0001);
    directed_request(CMD_DELETE, 32'd0, 32'd0, 64'd0);
    directed_request(CMD_ADD, 32'd0, 32'h5A5A_5A5A, 64'h0123_4567_89AB_CDEF);
    directed_request(CMD_ADD, 32'd7, 32'd7, 64'd7);
    directed_request(CMD_ADD, 32'd8, 32'd8, 64'd8);
    // table range full
    directed_request(CMD_ADD, 32'd9, 32'd9, 64'd9);
    directed_request(CMD_ADD, 32'd9, 32'd9, 64'd0);
    directed_request(CMD_LOOKUP, 32'hFFFF_FFFF, 32'd0, 64'd0);
    directed_request(CMD_DELETE, 32'd12345, 32'd0, 64'd0);
    directed_request(CMD_MODIFY, 32'd12345, 32'd1, 64'd1);

    // range above the slot count is clamped
    wait_replies_drained();
    write_search_range(7'd127);
    directed_request(CMD_LOOKUP, 32'd0, 32'd0, 64'd0);
    directed_request(CMD_LOOKUP, 32'd8, 32'd0, 64'd0);

    random_phase(7'd4, 120, 35);
    random_phase(7'd1, 80, 35);
    random_phase(7'd64, 250, 50);
    random_phase(7'd127, 200, 50);
    random_phase(7'd0, 40, 35);
    random_phase(7'd13, 120, 40);
    random_phase(7'($urandom_range(0, 127)), 100, 40);
    random_phase(7'($urandom_range(0, 127)), 100, 40);

    wait_replies_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d requests (%0d add, %0d modify, %0d delete, %0d lookup)",
             sent_by_cmd[0] + sent_by_cmd[1] + sent_by_cmd[2] + sent_by_cmd[3],
             sent_by_cmd[CMD_ADD], sent_by_cmd[CMD_MODIFY], sent_by_cmd[CMD_DELETE],
             sent_by_cmd[CMD_LOOKUP]);
    $display("over %0d search range settings; %0d replies checked, %0d failures",
             ranges_used, replies_checked, error_count);
    if (error_count == 0) begin
      $display("keyed_slot_table: match");
    end else begin
      $display("keyed_slot_table: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/kst_pkg.sv
sv/kst_ctrl.sv
sv/kst_dpath.sv
sv/keyed_slot_table.sv
sim/keyed_slot_table_checker.sv
sim/keyed_slot_table_tb.sv
